>>> src/fsp_pkg.sv
// shared types, constants and helpers for the format specifier parser
// no dependencies; imported by format_spec_parser_top
package fsp_pkg;

  // bits of the width and precision counters, saturating at 2^COUNT_BITS-1
  localparam int COUNT_BITS = 16;
  localparam int ACC_W      = COUNT_BITS + 5;
  localparam int FIELD_W    = 17;
  localparam int OUT_TDATA_W = 56;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_H       = 8'h68;
  localparam logic [7:0] CH_L       = 8'h6c;
  localparam logic [7:0] CH_J       = 8'h6a;
  localparam logic [7:0] CH_Z       = 8'h7a;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // parse position; ordering matters, later parts compare against it
  typedef enum logic [3:0] {
    PH_LIT   = 4'd0,
    PH_START = 4'd1,
    PH_SP1   = 4'd2,
    PH_PLUS  = 4'd4,
    PH_SP2   = 4'd5,
    PH_WIDTH = 4'd6,
    PH_PREC  = 4'd7,
    PH_HASH  = 4'd8,
    PH_HPEND = 4'd9,
    PH_LPEND = 4'd10,
    PH_CONV  = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    LEN_NONE = 3'd0,
    LEN_HH   = 3'd1,
    LEN_H    = 3'd2,
    LEN_LL   = 3'd3,
    LEN_L    = 3'd4,
    LEN_J    = 3'd5,
    LEN_Z    = 3'd6
  } len_t;

  typedef struct packed {
    logic alt;
    logic zero;
    logic space;
    logic plus;
    logic left;
  } flags_t;

  // index into "idDsScC%pUOXxou", 0 when not listed
  function automatic logic [3:0] conv_index(input logic [7:0] b);
    logic [3:0] idx;
    case (b)
      8'h69:   idx = 4'd0;
      8'h64:   idx = 4'd1;
      8'h44:   idx = 4'd2;
      8'h73:   idx = 4'd3;
      8'h53:   idx = 4'd4;
      8'h63:   idx = 4'd5;
      8'h43:   idx = 4'd6;
      8'h25:   idx = 4'd7;
      8'h70:   idx = 4'd8;
      8'h55:   idx = 4'd9;
      8'h4f:   idx = 4'd10;
      8'h58:   idx = 4'd11;
      8'h78:   idx = 4'd12;
      8'h6f:   idx = 4'd13;
      8'h75:   idx = 4'd14;
      default: idx = 4'd0;
    endcase
    return idx;
  endfunction

  // acc*10 + digit, an absent count starting from zero, saturating
  function automatic logic [COUNT_BITS-1:0] acc_digit(input logic [COUNT_BITS-1:0] val,
                                                    input logic present,
                                                    input logic [3:0] d);
    logic [ACC_W-1:0] base;
    logic [ACC_W-1:0] sum;
    base = present ? ACC_W'(val) : '0;
    sum  = (base << 3) + (base << 1) + ACC_W'(d);
    if (sum > ACC_W'({COUNT_BITS{1'b1}})) begin
      return {COUNT_BITS{1'b1}};
    end
    return sum[COUNT_BITS-1:0];
  endfunction

endpackage

>>> src/format_spec_parser_top.sv
// format specifier parser: byte stream in, literal bytes and specifier records out
// depends on fsp_pkg

// Takes a printf-style format string one byte per beat and returns each plain
// byte as a literal beat (tuser 0) and each complete '%' specifier as one record
// beat (tuser 1) carrying flags, width, precision, length modifier and conversion
// index. A zero byte ends the string; inside a specifier it closes the record with
// the early-end flag. The parse state and the result register both update on the
// accepting edge, so a result appears in the cycle after its byte, and a new byte is
// taken every cycle while the result register is empty or being drained. Bytes that
// only advance the parse give no result beat.
module format_spec_parser_top
  import fsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] char_in
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] byte_out, [8] left_align,
                                             // [9] show_plus, [10] space_flag,
                                             // [11] zero_pad, [12] alt_form,
                                             // [29:13] field_width, [46:30] precision,
                                             // [49:47] length_mod, [53:50] conversion,
                                             // [54] ended_early, [55] zero
  output logic                   out_tuser   // [0] kind
);

  phase_t                  phase_r, phase_nxt;
  flags_t                  flags_r, flags_nxt;
  logic [COUNT_BITS-1:0]   width_r, width_nxt;
  logic                    width_ok_r, width_ok_nxt;
  logic [COUNT_BITS-1:0]   prec_r, prec_nxt;
  logic                    prec_ok_r, prec_ok_nxt;
  len_t                    len_r, len_nxt;

  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;
  logic                    out_kind_r, out_kind_nxt;

  logic                    in_beat;
  logic                    emit;
  logic                    rec;
  logic                    early;
  logic [7:0]              rec_byte;
  logic                    digit;
  logic [7:0]              b;
  logic [FIELD_W-1:0]      width_field;
  logic [FIELD_W-1:0]      prec_field;

  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign digit     = (b >= CH_ZERO) && (b <= CH_NINE);

  always_comb begin
    phase_nxt    = phase_r;
    flags_nxt    = flags_r;
    width_nxt    = width_r;
    width_ok_nxt = width_ok_r;
    prec_nxt     = prec_r;
    prec_ok_nxt  = prec_ok_r;
    len_nxt      = len_r;
    emit         = 1'b0;
    rec          = 1'b0;
    early        = 1'b0;
    rec_byte     = b;

    if (phase_r == PH_LIT || phase_r > PH_CONV) begin
      phase_nxt = PH_LIT;
      if (b == CH_PERCENT) begin
        flags_nxt    = '0;
        width_ok_nxt = 1'b0;
        prec_ok_nxt  = 1'b0;
        len_nxt      = LEN_NONE;
        phase_nxt    = PH_START;
      end else if (b != CH_NUL) begin
        emit = 1'b1;
      end
    end else if (b == CH_NUL) begin
      // string ends mid-specifier: a pending h or l stands alone
      if (phase_r == PH_HPEND) begin
        len_nxt = LEN_H;
      end else if (phase_r == PH_LPEND) begin
        len_nxt = LEN_L;
      end
      emit      = 1'b1;
      rec       = 1'b1;
      early     = 1'b1;
      phase_nxt = PH_LIT;
    end else if (phase_r == PH_HPEND || phase_r == PH_LPEND) begin
      if (phase_r == PH_HPEND && b == CH_H) begin
        len_nxt   = LEN_HH;
        phase_nxt = PH_CONV;
      end else if (phase_r == PH_LPEND && b == CH_L) begin
        len_nxt   = LEN_LL;
        phase_nxt = PH_CONV;
      end else begin
        len_nxt   = (phase_r == PH_HPEND) ? LEN_H : LEN_L;
        emit      = 1'b1;
        rec       = 1'b1;
        phase_nxt = PH_LIT;
      end
    end else if (phase_r <= PH_SP1 && b == CH_SPACE) begin
      flags_nxt.space = 1'b1;
      phase_nxt       = PH_SP1;
    end else if (phase_r <= PH_SP1 && b == CH_MINUS) begin
      flags_nxt.left = 1'b1;
      phase_nxt      = PH_PLUS;
    end else if (phase_r <= PH_PLUS && b == CH_PLUS) begin
      flags_nxt.plus = 1'b1;
      phase_nxt      = PH_PLUS;
    end else if (phase_r <= PH_SP2 && b == CH_SPACE) begin
      flags_nxt.space = 1'b1;
      phase_nxt       = PH_SP2;
    end else if (phase_r == PH_START && b == CH_ZERO) begin
      flags_nxt.zero = 1'b1;
      phase_nxt      = PH_WIDTH;
    end else if (phase_r <= PH_WIDTH && digit) begin
      width_nxt    = acc_digit(width_r, width_ok_r, b[3:0]);
      width_ok_nxt = 1'b1;
      phase_nxt    = PH_WIDTH;
    end else if (phase_r <= PH_WIDTH && b == CH_DOT) begin
      // empty precision reads as zero
      prec_nxt    = '0;
      prec_ok_nxt = 1'b1;
      phase_nxt   = PH_PREC;
    end else if (phase_r == PH_PREC && digit) begin
      prec_nxt    = acc_digit(prec_r, prec_ok_r, b[3:0]);
      prec_ok_nxt = 1'b1;
    end else if (phase_r <= PH_PREC && b == CH_HASH) begin
      flags_nxt.alt = 1'b1;
      phase_nxt     = PH_HASH;
    end else if (phase_r <= PH_HASH && b == CH_H) begin
      phase_nxt = PH_HPEND;
    end else if (phase_r <= PH_HASH && b == CH_L) begin
      phase_nxt = PH_LPEND;
    end else if (phase_r <= PH_HASH && b == CH_J) begin
      len_nxt   = LEN_J;
      phase_nxt = PH_CONV;
    end else if (phase_r <= PH_HASH && b == CH_Z) begin
      len_nxt   = LEN_Z;
      phase_nxt = PH_CONV;
    end else begin
      emit      = 1'b1;
      rec       = 1'b1;
      phase_nxt = PH_LIT;
    end
  end

  assign width_field = width_ok_r ? FIELD_W'(width_r) : {FIELD_W{1'b1}};
  assign prec_field  = prec_ok_r  ? FIELD_W'(prec_r)  : {FIELD_W{1'b1}};

  always_comb begin
    out_kind_nxt = rec;
    out_data_nxt = '0;
    if (rec) begin
      out_data_nxt[7:0]   = early ? CH_NUL : rec_byte;
      out_data_nxt[8]     = flags_r.left;
      out_data_nxt[9]     = flags_r.plus;
      out_data_nxt[10]    = flags_r.space;
      out_data_nxt[11]    = flags_r.zero;
      out_data_nxt[12]    = flags_r.alt;
      out_data_nxt[29:13] = width_field;
      out_data_nxt[46:30] = prec_field;
      out_data_nxt[49:47] = len_nxt;
      out_data_nxt[53:50] = early ? 4'd0 : conv_index(rec_byte);
      out_data_nxt[54]    = early;
    end else begin
      out_data_nxt[7:0] = b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LIT;
      flags_r     <= '0;
      width_ok_r  <= 1'b0;
      prec_ok_r   <= 1'b0;
      len_r       <= LEN_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat) begin
        phase_r    <= phase_nxt;
        flags_r    <= flags_nxt;
        width_ok_r <= width_ok_nxt;
        prec_ok_r  <= prec_ok_nxt;
        len_r      <= len_nxt;
      end
      if (in_beat && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      width_r <= width_nxt;
      prec_r  <= prec_nxt;
    end
    if (in_beat && emit) begin
      out_data_r <= out_data_nxt;
      out_kind_r <= out_kind_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  // literal beats carry nothing above the byte
  a_literal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_kind_r |-> out_data_r[OUT_TDATA_W-1:8] == '0)
    else $error("literal beat with non-zero record fields");

  // an early-end record has no conversion byte
  a_early_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r && out_data_r[54] |->
      out_data_r[7:0] == CH_NUL && out_data_r[53:50] == 4'd0)
    else $error("early-end record with conversion data");

  // terminator inside a specifier closes it with a record
  a_term_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && phase_r != PH_LIT && in_tdata == CH_NUL |=>
      phase_r == PH_LIT && out_valid_r && out_kind_r)
    else $error("terminator did not close the specifier");

  // terminator between specifiers gives no beat
  a_term_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && phase_r == PH_LIT && in_tdata == CH_NUL && !out_valid_r |=> !out_valid_r)
    else $error("terminator outside a specifier produced a beat");

endmodule
